// ----- rtl/scba_pkg.sv -----
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size class block allocator
// Size class map, status and operation codes, controller states and the
// request group handed to the byte meter.
// ----------------------------------------------------------------------------
package scba_pkg;

    // Default pool geometry
    localparam int NUM_CHUNKS_DEF  = 64;
    localparam int CHUNK_BYTES_DEF = 1024;

    // Heap addressing and link memory
    localparam int ADDR_W       = 16;
    localparam int GRAN_SHIFT   = 3;
    localparam int GRAN_W       = ADDR_W - GRAN_SHIFT;
    localparam int LINK_DEPTH   = 1 << GRAN_W;
    localparam int LINK_W       = GRAN_W + 1;
    localparam int GRAN_BYTES   = 8;
    localparam int SMALL_MAX    = 64;
    localparam int NUM_CLASSES  = 4;
    localparam int CLASS_W      = 2;

    // Byte counter
    localparam int             BYTES_W      = 32;
    localparam logic [31:0]    THRESH_RESET = 32'd65536;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_SMALL = 2'd0,
        STAT_LARGE = 2'd1,
        STAT_OOM   = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Update request for the byte meter
    typedef struct packed {
        logic        upd;
        logic        is_free;
        logic [15:0] size;
    } t_meter_req;

    // Granule-count (size-1)/8 to class
    localparam logic [CLASS_W-1:0] CLASS_MAP [8] = '{
        2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3
    };

    // Class of a small size; size zero falls in class 0
    function automatic logic [CLASS_W-1:0] pick_class(input logic [15:0] z);
        logic [15:0] zm;
        zm = z - 16'd1;
        if (z == 16'd0) begin
            return '0;
        end
        return CLASS_MAP[zm[5:3]];
    endfunction

endpackage

// ----- rtl/scba_byte_meter.sv -----
// ----------------------------------------------------------------------------
// scba_byte_meter: bytes-in-use counter and collection threshold
// Adds allocated sizes saturating at the top, subtracts freed sizes flooring
// at zero, and flags when the updated count exceeds the threshold register.
// ----------------------------------------------------------------------------
module scba_byte_meter
    import scba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [BYTES_W-1:0] i_cfg_data,
    input  t_meter_req         i_req,
    output logic               o_collect
);

    logic [BYTES_W-1:0] r_thresh;
    logic [BYTES_W-1:0] r_bytes;
    logic [BYTES_W-1:0] n_bytes;
    logic [BYTES_W:0]   add_sum;
    logic [BYTES_W-1:0] size_ext;

    // Saturating add / flooring subtract
    always_comb begin
        size_ext = BYTES_W'(i_req.size);
        add_sum  = {1'b0, r_bytes} + {1'b0, size_ext};
        if (i_req.is_free) begin
            n_bytes = (r_bytes < size_ext) ? '0 : r_bytes - size_ext;
        end else begin
            n_bytes = add_sum[BYTES_W] ? '1 : add_sum[BYTES_W-1:0];
        end
    end

    assign o_collect = (n_bytes > r_thresh);

    // Counter and threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes  <= '0;
            r_thresh <= THRESH_RESET;
        end else begin
            if (i_req.upd) begin
                r_bytes <= n_bytes;
            end
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
        end
    end

endmodule

// ----- rtl/size_class_block_allocator.sv -----
// ----------------------------------------------------------------------------
// size_class_block_allocator: four-class slab allocator with LIFO free lists
// Small requests pop or push per-class free lists linked through a link
// memory, fall back to a bump pointer and then to fresh pool chunks.
// ----------------------------------------------------------------------------
// Flow: accept in idle, then the execute state writes the result into the output
//   register, waiting while that register holds an untaken result; a new request
//   is taken only after that. The link memory read issued at accept is registered
//   for the execute update. The output register frees the input while a result waits.
// Reset: synchronous active low; empties all free lists, clears the bump
//   pointers, chunk count and byte counter, threshold back to 65536.
// ----------------------------------------------------------------------------
module size_class_block_allocator
    import scba_pkg::*;
#(
    parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: collect_threshold
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] size, [31:16] block_address
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] result_address, [17:16] size_class,
                                        // [18] collect_request, [23:19] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // Pool address width holds the pool end plus one block
    localparam int POOL_BYTES = NUM_CHUNKS * CHUNK_BYTES;
    localparam int BW         = $clog2(POOL_BYTES + SMALL_MAX + 1);
    localparam int CW         = $clog2(NUM_CHUNKS + 1);
    localparam int EW         = (BW > ADDR_W) ? BW : ADDR_W;

    // Controller
    t_state r_state, n_state;
    logic   in_fire;
    logic   exec_done;

    // Latched request
    logic               r_op;
    logic [15:0]        r_size;
    logic [ADDR_W-1:0]  r_addr;
    logic [CLASS_W-1:0] r_cls;
    logic               r_small;

    // Per-class heads and bump pointers
    logic [ADDR_W-1:0] r_head_addr [NUM_CLASSES];
    logic              r_head_vld  [NUM_CLASSES];
    logic [BW-1:0]     r_bump_next [NUM_CLASSES];
    logic [BW-1:0]     r_bump_end  [NUM_CLASSES];
    logic [ADDR_W-1:0] n_head_addr [NUM_CLASSES];
    logic              n_head_vld  [NUM_CLASSES];
    logic [BW-1:0]     n_bump_next [NUM_CLASSES];
    logic [BW-1:0]     n_bump_end  [NUM_CLASSES];
    logic [CW-1:0]     r_chunks, n_chunks;
    logic [BW-1:0]     r_chunk_base, n_chunk_base;

    // Link memory
    logic [LINK_W-1:0] link_mem [LINK_DEPTH];
    logic [LINK_W-1:0] r_link_rd;
    logic [GRAN_W-1:0] link_ra;
    logic              link_we;
    logic [GRAN_W-1:0] link_wa;
    logic [LINK_W-1:0] link_wd;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    t_status            r_out_status, n_out_status;
    logic [CLASS_W-1:0] r_out_cls;
    logic               r_out_collect;

    // Request decode
    logic [15:0]        in_size;
    logic [CLASS_W-1:0] in_cls;
    logic [CLASS_W-1:0] head_sel;
    logic [ADDR_W-1:0]  head_addr;
    logic               head_vld;

    // Execute-cycle arithmetic
    logic [BW-1:0] cz;
    logic [BW-1:0] bump_sum;
    logic [EW-1:0] wide_next;
    logic [EW-1:0] wide_base;

    t_meter_req meter_req;
    logic       collect;

    assign o_cfg_ready = 1'b1;
    assign in_size     = s_axis_tdata[15:0];
    assign in_cls      = pick_class(in_size);

    // One head read port: incoming class at accept, latched class afterwards
    assign head_sel  = (r_state == ST_IDLE) ? in_cls : r_cls;
    assign head_addr = r_head_addr[head_sel];
    assign head_vld  = r_head_vld[head_sel];
    assign link_ra   = head_addr[ADDR_W-1:GRAN_SHIFT];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        exec_done     = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EXEC: exec_done     = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Allocator update, evaluated in the execute cycle
    always_comb begin
        n_head_addr  = r_head_addr;
        n_head_vld   = r_head_vld;
        n_bump_next  = r_bump_next;
        n_bump_end   = r_bump_end;
        n_chunks     = r_chunks;
        n_chunk_base = r_chunk_base;
        n_out_addr   = '0;
        n_out_status = STAT_SMALL;
        link_we      = 1'b0;
        link_wa      = r_addr[ADDR_W-1:GRAN_SHIFT];
        link_wd      = head_vld ? {1'b1, head_addr[ADDR_W-1:GRAN_SHIFT]} : '0;

        cz        = BW'(GRAN_BYTES) << r_cls;
        bump_sum  = r_bump_next[r_cls] + cz;
        wide_next = EW'(r_bump_next[r_cls]);
        wide_base = EW'(r_chunk_base);

        if (r_op == OP_FREE) begin
            n_out_addr = r_addr;
            if (!r_small) begin
                n_out_status = STAT_LARGE;
            end else begin
                // Push the granule onto the class list
                link_we            = exec_done;
                n_head_vld[r_cls]  = 1'b1;
                n_head_addr[r_cls] = {r_addr[ADDR_W-1:GRAN_SHIFT], GRAN_SHIFT'(0)};
            end
        end else if (!r_small) begin
            n_out_status = STAT_LARGE;
        end else if (head_vld) begin
            // Pop: successor comes from the link read issued at accept
            n_out_addr         = head_addr;
            n_head_vld[r_cls]  = r_link_rd[LINK_W-1];
            n_head_addr[r_cls] = {r_link_rd[GRAN_W-1:0], GRAN_SHIFT'(0)};
        end else if (bump_sum <= r_bump_end[r_cls]) begin
            n_out_addr         = wide_next[ADDR_W-1:0];
            n_bump_next[r_cls] = bump_sum;
        end else if (r_chunks < CW'(NUM_CHUNKS)) begin
            // Carve a fresh chunk for this class
            n_out_addr         = wide_base[ADDR_W-1:0];
            n_bump_end[r_cls]  = r_chunk_base + BW'(CHUNK_BYTES);
            n_bump_next[r_cls] = r_chunk_base + cz;
            n_chunk_base       = r_chunk_base + BW'(CHUNK_BYTES);
            n_chunks           = r_chunks + CW'(1);
        end else begin
            n_out_status = STAT_OOM;
        end
    end

    // Byte accounting
    assign meter_req.upd     = exec_done;
    assign meter_req.is_free = (r_op == OP_FREE);
    assign meter_req.size    = r_size;

    scba_byte_meter u_meter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_req       (meter_req),
        .o_collect   (collect)
    );

    // Link memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (in_fire) begin
            r_link_rd <= link_mem[link_ra];
        end
    end

    // Output valid next value
    always_comb begin
        n_out_valid = r_out_valid;
        if (exec_done) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_chunks     <= '0;
            r_chunk_base <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_head_vld[i]  <= 1'b0;
                r_bump_next[i] <= '0;
                r_bump_end[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (exec_done) begin
                r_chunks     <= n_chunks;
                r_chunk_base <= n_chunk_base;
                r_head_vld   <= n_head_vld;
                r_bump_next  <= n_bump_next;
                r_bump_end   <= n_bump_end;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= s_axis_tuser[0];
            r_size  <= in_size;
            r_addr  <= s_axis_tdata[31:16];
            r_cls   <= (in_size > 16'(SMALL_MAX)) ? '0 : in_cls;
            r_small <= (in_size <= 16'(SMALL_MAX));
        end
        if (exec_done) begin
            r_head_addr   <= n_head_addr;
            r_out_addr    <= n_out_addr;
            r_out_status  <= n_out_status;
            r_out_cls     <= r_cls;
            r_out_collect <= collect;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_collect, r_out_cls, r_out_addr};
    assign m_axis_tuser  = r_out_status;

endmodule

// ----- test/size_class_block_allocator_test.sv -----
// ----------------------------------------------------------------------------
// size_class_block_allocator_test: self-checking bench for the slab allocator
// Sends alloc and free requests through the block and predicts every result
// from a behavioral copy of the class free lists, bump pointers, chunk pool
// and byte meter. Each result transaction is checked field by field. The run
// goes through several back-pressure patterns, threshold settings and one
// long receiver hold-off, and it drives the pool into out-of-memory.
// ----------------------------------------------------------------------------
module size_class_block_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scba_pkg::*;

    // Bench geometry and limits
    localparam int          POOL_CHUNKS  = NUM_CHUNKS_DEF;
    localparam int          CHUNK_SIZE   = CHUNK_BYTES_DEF;
    localparam int          CLASSES      = 4;
    localparam int          LINK_ENTRIES = 8192;
    localparam int          MAX_SMALL    = 64;
    localparam int          GRANULE      = 8;
    localparam logic [31:0] RESET_LIMIT  = 32'd65536;
    localparam int          FIFO_DEPTH   = 4;
    localparam int          HOLD_LEN     = 300;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic        op;
        logic [15:0] size;
        logic [15:0] addr;
    } alloc_req_t;

    typedef struct packed {
        logic [15:0] addr;
        t_status     status;
        logic [1:0]  cls;
        logic        collect;
    } alloc_rsp_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  cls;
    } live_block_t;

    // DUT ports
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data    = 32'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'd0;  // [15:0] size, [31:16] block_address
    logic [0:0]  s_axis_tuser  = 1'b0;   // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [15:0] result_address, [17:16] size_class,
                                         // [18] collect_request, [23:19] zero
    logic [1:0]  m_axis_tuser;           // [1:0] status

    // Request and result bookkeeping
    alloc_req_t  pending_reqs[$];
    alloc_rsp_t  pending_results[$];
    live_block_t live_blocks[$];
    alloc_req_t  offered_req;
    alloc_req_t  next_req;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned oom_count      = 0;
    int unsigned cycle_count    = 0;
    logic        hold_go        = 1'b0;
    int unsigned hold_cycles    = 0;
    logic        hold_active;

    // Predicted allocator state
    logic        head_ok   [CLASSES];
    logic [15:0] head_addr [CLASSES];
    logic [13:0] link_mem  [LINK_ENTRIES];  // [13] valid, [12:0] next granule
    logic [16:0] bump_ptr  [CLASSES];
    logic [16:0] bump_lim  [CLASSES];
    logic [6:0]  chunk_count;
    logic [31:0] bytes_used;
    logic [31:0] collect_limit;

    size_class_block_allocator #(
        .NUM_CHUNKS  (POOL_CHUNKS),
        .CHUNK_BYTES (CHUNK_SIZE)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Class of a small size; zero maps to the 8-byte class
    function automatic logic [1:0] size_to_class(logic [15:0] z);
        if (z <= 16'd8) return 2'd0;
        if (z <= 16'd16) return 2'd1;
        if (z <= 16'd32) return 2'd2;
        return 2'd3;
    endfunction

    // Random byte size that falls in the given class
    function automatic int unsigned class_size(logic [1:0] cls);
        int unsigned hi;
        int unsigned lo;
        hi = GRANULE << cls;
        lo = (cls == 2'd0) ? 0 : (hi / 2) + 1;
        return $urandom_range(lo, hi);
    endfunction

    // Apply one request to the predicted state and return its result
    function automatic alloc_rsp_t allocate_or_free(alloc_req_t r);
        alloc_rsp_t  rsp;
        logic [32:0] sum;
        logic [16:0] blk;
        logic [16:0] base;
        logic [13:0] lnk;
        logic [12:0] gran;
        logic [1:0]  c;
        rsp.addr    = 16'd0;
        rsp.status  = STAT_SMALL;
        rsp.cls     = 2'd0;
        rsp.collect = 1'b0;
        if (r.op == OP_ALLOC) begin
            // byte meter saturates at the top
            sum = {1'b0, bytes_used} + 33'(r.size);
            bytes_used = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (r.size > MAX_SMALL) begin
                rsp.status = STAT_LARGE;
            end else begin
                c       = size_to_class(r.size);
                rsp.cls = c;
                blk     = 17'(GRANULE) << c;
                if (head_ok[c]) begin
                    // pop the class list
                    rsp.addr     = head_addr[c];
                    lnk          = link_mem[head_addr[c][15:3]];
                    head_ok[c]   = lnk[13];
                    head_addr[c] = {lnk[12:0], 3'b000};
                end else if (bump_ptr[c] + blk <= bump_lim[c]) begin
                    rsp.addr    = bump_ptr[c][15:0];
                    bump_ptr[c] = bump_ptr[c] + blk;
                end else if (chunk_count < POOL_CHUNKS) begin
                    // carve a fresh chunk for this class
                    base        = 17'(chunk_count) * 17'(CHUNK_SIZE);
                    chunk_count = chunk_count + 7'd1;
                    bump_lim[c] = base + 17'(CHUNK_SIZE);
                    bump_ptr[c] = base + blk;
                    rsp.addr    = base[15:0];
                end else begin
                    rsp.status = STAT_OOM;
                    oom_count++;
                end
                if (rsp.status == STAT_SMALL) live_blocks.push_back('{rsp.addr, c});
            end
        end else begin
            rsp.addr   = r.addr;
            bytes_used = (bytes_used < 32'(r.size)) ? 32'd0 : bytes_used - 32'(r.size);
            if (r.size > MAX_SMALL) begin
                rsp.status = STAT_LARGE;
            end else begin
                // push the granule onto the class list
                c             = size_to_class(r.size);
                rsp.cls       = c;
                gran          = r.addr[15:3];
                link_mem[gran] = head_ok[c] ? {1'b1, head_addr[c][15:3]} : 14'd0;
                head_ok[c]    = 1'b1;
                head_addr[c]  = {gran, 3'b000};
            end
        end
        rsp.collect = (bytes_used > collect_limit);
        return rsp;
    endfunction

    function automatic void flag_error(string what, alloc_rsp_t want, alloc_rsp_t got);
        if (error_count < 10) begin
            $display("%0t %s: expected addr %h status %0d class %0d collect %0b, got addr %h status %0d class %0d collect %0b",
                     $time, what, want.addr, want.status, want.cls, want.collect,
                     got.addr, got.status, got.cls, got.collect);
        end
        error_count++;
    endfunction

    // Request driver: predicts each transaction as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(allocate_or_free(offered_req));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req      = pending_reqs.pop_front();
                    offered_req   = next_req;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {next_req.addr, next_req.size};
                    s_axis_tuser  <= next_req.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        alloc_rsp_t want;
        alloc_rsp_t got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.addr    = m_axis_tdata[15:0];
                got.cls     = m_axis_tdata[17:16];
                got.collect = m_axis_tdata[18];
                got.status  = t_status'(m_axis_tuser);
                if (pending_results.size() == 0) begin
                    want = '0;
                    flag_error("result with nothing pending", want, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.addr !== want.addr || got.status !== want.status ||
                        got.cls !== want.cls || got.collect !== want.collect) begin
                        flag_error("result mismatch", want, got);
                    end
                end
            end
            m_axis_tready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge i_clk) begin
        if (!hold_go) begin
            hold_cycles <= 0;
        end else if (hold_cycles < HOLD_LEN) begin
            hold_cycles <= hold_cycles + 1;
        end
    end
    assign hold_active = hold_go && (hold_cycles < HOLD_LEN);

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_req(logic op, int unsigned size, int unsigned addr);
        alloc_req_t r;
        while (pending_reqs.size() >= FIFO_DEPTH) @(negedge i_clk);
        r.op   = op;
        r.size = size[15:0];
        r.addr = addr[15:0];
        pending_reqs.push_back(r);
    endtask

    // One random request; hungry mode mostly grabs 64-byte blocks
    task automatic queue_random(bit hungry);
        int unsigned pick;
        int unsigned idx;
        live_block_t blk;
        logic [15:0] where;
        pick = $urandom_range(0, 99);
        if (hungry && pick < 90) begin
            queue_req(OP_ALLOC, $urandom_range(33, MAX_SMALL), $urandom);
        end else if (pick < 45 || (hungry && pick < 95)) begin
            queue_req(OP_ALLOC, $urandom_range(0, MAX_SMALL), $urandom);
        end else if (pick < 55) begin
            queue_req(OP_ALLOC, $urandom_range(MAX_SMALL + 1, 65535), $urandom);
        end else if ((pick < 90 || hungry) && live_blocks.size() != 0) begin
            // well-formed free of a block handed out earlier
            idx   = $urandom_range(0, live_blocks.size() - 1);
            blk   = live_blocks[idx];
            live_blocks.delete(idx);
            where = blk.addr;
            if ($urandom_range(0, 3) == 0) where[2:0] = 3'($urandom_range(0, 7));
            queue_req(OP_FREE, class_size(blk.cls), where);
        end else if (pick < 95) begin
            queue_req(OP_FREE, $urandom_range(MAX_SMALL + 1, 65535), $urandom);
        end else begin
            // stray free of an arbitrary address
            queue_req(OP_FREE, $urandom_range(0, MAX_SMALL), $urandom);
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_axis_tvalid || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_limit(logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        collect_limit = value;
    endtask

    task automatic set_pace(int unsigned send_pct, int unsigned recv_pct);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Stimulus sequence
    initial begin
        int unsigned n;
        for (int c = 0; c < CLASSES; c++) begin
            head_ok[c]   = 1'b0;
            head_addr[c] = 16'd0;
            bump_ptr[c]  = 17'd0;
            bump_lim[c]  = 17'd0;
        end
        chunk_count   = 7'd0;
        bytes_used    = 32'd0;
        collect_limit = RESET_LIMIT;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: class edges, large sizes, list push/pop, floor at zero
        queue_req(OP_ALLOC, 0, 16'h0000);
        queue_req(OP_ALLOC, 1, 16'hFFFF);
        queue_req(OP_ALLOC, 8, 16'h0000);
        queue_req(OP_ALLOC, 9, 16'h0000);
        queue_req(OP_ALLOC, 16, 16'h0000);
        queue_req(OP_ALLOC, 17, 16'h0000);
        queue_req(OP_ALLOC, 32, 16'h0000);
        queue_req(OP_ALLOC, 33, 16'h0000);
        queue_req(OP_ALLOC, 64, 16'h0000);
        queue_req(OP_ALLOC, 65, 16'h0000);
        queue_req(OP_ALLOC, 65535, 16'h0000);
        queue_req(OP_FREE, 64, 16'h0C05);     // unaligned free
        queue_req(OP_ALLOC, 64, 16'h0000);
        queue_req(OP_FREE, 40, 16'hFFFF);
        queue_req(OP_FREE, 48, 16'h1238);
        queue_req(OP_ALLOC, 64, 16'h0000);
        queue_req(OP_ALLOC, 64, 16'h0000);
        queue_req(OP_ALLOC, 64, 16'h0000);    // list empty again, back to bump
        queue_req(OP_FREE, 0, 16'h0000);
        queue_req(OP_ALLOC, 0, 16'h0000);
        queue_req(OP_FREE, 65535, 16'hFFFF);
        queue_req(OP_FREE, 65535, 16'h0000);  // meter floors at zero
        wait_idle();

        // Mixed traffic, no idling, collect on any use
        write_limit(32'd0);
        repeat (400) queue_random(1'b0);
        wait_idle();

        // Mixed traffic, sparse sender, collect never
        write_limit(32'hFFFF_FFFF);
        set_pace(80, 0);
        repeat (300) queue_random(1'b0);
        wait_idle();

        // Pool exhaustion under receiver stalls and one long hold-off
        write_limit($urandom);
        set_pace(0, 80);
        hold_go = 1'b1;
        n = 0;
        while (oom_count < 40 && n < 3000) begin
            queue_random(1'b1);
            n++;
        end
        wait_idle();
        @(negedge i_clk);
        hold_go = 1'b0;

        // Mixed traffic on a full pool, threshold at the current usage
        write_limit(bytes_used);
        set_pace(35, 35);
        repeat (500) queue_random(1'b0);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/scba_pkg.sv
rtl/scba_byte_meter.sv
rtl/size_class_block_allocator.sv
test/size_class_block_allocator_test.sv
